[rtl/yccb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yccb_pkg: colour bar generator package
// Field widths, plane and register codes, bar colour tables and the result
// transaction type shared by the generator, its output buffer and checker.
// ----------------------------------------------------------------------------
package yccb_pkg;

  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned PLANE_W   = 2;
  localparam int unsigned COL_W     = 12;
  localparam int unsigned LINE_W    = 12;
  localparam int unsigned SAMPLE_W  = 8;

  localparam int unsigned DEF_MAX_WIDTH      = 4096;
  localparam int unsigned DEF_MAX_HEIGHT     = 4096;
  localparam int unsigned MIN_WIDTH          = 8;
  localparam int unsigned MIN_HEIGHT         = 2;
  localparam int unsigned RESET_FRAME_WIDTH  = 1280;
  localparam int unsigned RESET_FRAME_HEIGHT = 720;

  localparam int unsigned NUM_BARS     = 8;
  localparam int unsigned BAR_W        = 3;
  localparam int unsigned BAR_SHIFT    = 3;
  localparam int unsigned TICKER_COLS  = 4;
  localparam logic [SAMPLE_W-1:0] TICKER_LUMA = 8'd235;

  typedef enum logic [PLANE_W-1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // bt.601 conversions of the eight rgb bars
  localparam logic [SAMPLE_W-1:0] BAR_Y [NUM_BARS] =
    '{8'd218, 8'd197, 8'd161, 8'd140, 8'd108, 8'd86, 8'd51, 8'd30};
  localparam logic [SAMPLE_W-1:0] BAR_U [NUM_BARS] =
    '{8'd128, 8'd32, 8'd161, 8'd65, 8'd191, 8'd95, 8'd224, 8'd128};
  localparam logic [SAMPLE_W-1:0] BAR_V [NUM_BARS] =
    '{8'd128, 8'd143, 8'd32, 8'd48, 8'd208, 8'd224, 8'd113, 8'd128};

  typedef struct packed {
    logic [PLANE_W-1:0]  plane_select;
    logic [COL_W-1:0]    column;
    logic [LINE_W-1:0]   line_number;
    logic [SAMPLE_W-1:0] sample_value;
    logic                frame_end;
  } result_t;

endpackage

[rtl/yccb_skid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yccb_skid: two-entry output buffer
// Output register plus a skid entry; the upstream stall is taken from a
// register so a held result never blocks the next transaction.
// ----------------------------------------------------------------------------
module yccb_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  yccb_pkg::result_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output yccb_pkg::result_t out_data_o
);
  import yccb_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_data_q, skid_data_q;
  logic    in_acc;
  logic    out_free;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q && out_stall_i;
    skid_valid_d = skid_valid_q;
    if (out_free && skid_valid_q) begin
      out_valid_d  = 1'b1;
      skid_valid_d = 1'b0;
    end else if (in_acc) begin
      if (out_free) begin
        out_valid_d = 1'b1;
      end else begin
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && skid_valid_q) begin
      out_data_q <= skid_data_q;
    end else if (in_acc && out_free) begin
      out_data_q <= in_data_i;
    end
    if (in_acc && !out_free) begin
      skid_data_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[rtl/yuv420_color_bar_pattern_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_color_bar_pattern_generator: eight-bar yuv 4:2:0 test source
// Each request transaction produces the next planar sample (Y, then U, then
// V) of a colour bar frame with a moving white ticker on the luma plane.
// ----------------------------------------------------------------------------
// One request yields one sample transaction; a new request is taken every
// clock unless stalled. Bar selection is a set of parallel compares against
// the multiples of the bar width, so throughput is set by the single pass
// from position counters to the output register. A two-entry output buffer
// lets requests keep flowing while one result is held; in_stall_o rises
// only once both entries are occupied.
module yuv420_color_bar_pattern_generator #(
  parameter int unsigned MAX_WIDTH  = yccb_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = yccb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [yccb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [yccb_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           restart_frame_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [yccb_pkg::PLANE_W-1:0]   plane_select_o,
  output logic [yccb_pkg::COL_W-1:0]     column_o,
  output logic [yccb_pkg::LINE_W-1:0]    line_number_o,
  output logic [yccb_pkg::SAMPLE_W-1:0]  sample_value_o,
  output logic                           frame_end_o
);
  import yccb_pkg::*;

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

  function automatic logic [WW-1:0] clamp_w(input logic [CFG_W-1:0] v);
    logic [WW-1:0] r;
    if (int'(v) < MIN_WIDTH) begin
      r = WW'(MIN_WIDTH);
    end else if (int'(v) > MAX_WIDTH) begin
      r = WW'(MAX_WIDTH);
    end else begin
      r = WW'(v);
    end
    return r;
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [CFG_W-1:0] v);
    logic [HW-1:0] r;
    if (int'(v) < MIN_HEIGHT) begin
      r = HW'(MIN_HEIGHT);
    end else if (int'(v) > MAX_HEIGHT) begin
      r = HW'(MAX_HEIGHT);
    end else begin
      r = HW'(v);
    end
    return r;
  endfunction

  logic [WW-1:0] width_q;
  logic [HW-1:0] height_q;
  logic [WW-1:0] col_q, col_d;
  logic [HW-1:0] line_q, line_d;
  plane_e        plane_q, plane_d;
  logic [WW-1:0] tick_q, tick_d;

  logic          in_acc;
  logic          buf_stall;
  result_t       res_d, res_o;

  assign in_acc     = in_valid_i && !buf_stall;
  assign in_stall_o = buf_stall;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= clamp_w(CFG_W'(RESET_FRAME_WIDTH));
      height_q <= clamp_h(CFG_W'(RESET_FRAME_HEIGHT));
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  width_q  <= clamp_w(cfg_wdata_i);
        REG_FRAME_HEIGHT: height_q <= clamp_h(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // sample computation and position advance
  always_comb begin
    logic [WW-1:0]   col_r, tick_r, tick_c, col_c, pw, scaled, bw, thr, dt;
    logic [HW-1:0]   line_r, line_c, ph;
    plane_e          plane_r, plane_c;
    logic [BAR_W-1:0] bar;
    logic [SAMPLE_W-1:0] value;
    logic            col_end, line_end, hit;
    logic [WW:0]     tsum;

    col_r   = restart_frame_i ? '0 : col_q;
    line_r  = restart_frame_i ? '0 : line_q;
    plane_r = restart_frame_i ? PLANE_Y : plane_q;
    tick_r  = restart_frame_i ? '0 : tick_q;
    tick_c  = (tick_r >= width_q) ? '0 : tick_r;

    pw = (plane_r == PLANE_Y) ? width_q : (width_q >> 1);
    ph = (plane_r == PLANE_Y) ? height_q : (height_q >> 1);
    if (plane_r > PLANE_V || col_r >= pw || line_r >= ph) begin
      col_c   = '0;
      line_c  = '0;
      plane_c = PLANE_Y;
      pw      = width_q;
      ph      = height_q;
    end else begin
      col_c   = col_r;
      line_c  = line_r;
      plane_c = plane_r;
    end

    scaled = (plane_c == PLANE_Y) ? col_c : (col_c << 1);
    bw     = width_q >> BAR_SHIFT;
    bar    = '0;
    for (int k = 1; k < NUM_BARS; k++) begin
      thr = WW'(k * bw);
      if (scaled >= thr) begin
        bar = bar + BAR_W'(1);
      end
    end

    case (plane_c)
      PLANE_Y: value = BAR_Y[bar];
      PLANE_U: value = BAR_U[bar];
      default: value = BAR_V[bar];
    endcase

    dt  = col_c - tick_c;
    hit = (plane_c == PLANE_Y) && (col_c >= tick_c) && (dt < WW'(TICKER_COLS));
    if (hit) begin
      value = TICKER_LUMA;
    end

    col_end  = (col_c == pw - WW'(1));
    line_end = (line_c == ph - HW'(1));

    res_d.plane_select = plane_c;
    res_d.column       = COL_W'(col_c);
    res_d.line_number  = LINE_W'(line_c);
    res_d.sample_value = value;
    res_d.frame_end    = (plane_c == PLANE_V) && col_end && line_end;

    col_d   = col_end ? '0 : col_c + WW'(1);
    line_d  = line_c;
    plane_d = plane_c;
    tick_d  = tick_c;
    tsum    = (WW + 1)'(tick_c) + (WW + 1)'(TICKER_COLS);
    if (col_end) begin
      line_d = line_end ? '0 : line_c + HW'(1);
      if (line_end) begin
        case (plane_c)
          PLANE_Y: plane_d = PLANE_U;
          PLANE_U: plane_d = PLANE_V;
          default: begin
            plane_d = PLANE_Y;
            tick_d  = (tsum >= (WW + 1)'(width_q)) ? WW'(tsum - (WW + 1)'(width_q))
                                                   : WW'(tsum);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      line_q  <= '0;
      plane_q <= PLANE_Y;
      tick_q  <= '0;
    end else if (in_acc) begin
      col_q   <= col_d;
      line_q  <= line_d;
      plane_q <= plane_d;
      tick_q  <= tick_d;
    end
  end

  yccb_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (buf_stall),
    .in_data_i   (res_d),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (res_o)
  );

  assign plane_select_o = res_o.plane_select;
  assign column_o       = res_o.column;
  assign line_number_o  = res_o.line_number;
  assign sample_value_o = res_o.sample_value;
  assign frame_end_o    = res_o.frame_end;

endmodule

[rtl/yccb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yccb_checker: port-level checks for the colour bar generator
// Watches the request and sample transactions at the top level ports.
// ----------------------------------------------------------------------------
module yccb_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_stall_i,
  input logic                           out_valid_i,
  input logic                           out_stall_i,
  input logic [yccb_pkg::PLANE_W-1:0]   plane_select_i,
  input logic [yccb_pkg::COL_W-1:0]     column_i,
  input logic [yccb_pkg::SAMPLE_W-1:0]  sample_value_i,
  input logic                           frame_end_i
);
  import yccb_pkg::*;

  // held sample stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(column_i)
      && $stable(sample_value_i) && $stable(plane_select_i))
    else $error("stalled sample transaction changed");

  // frame end only on the V plane
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_end_i |-> plane_select_i == PLANE_V)
    else $error("frame end outside V plane");

  // no fourth plane code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> plane_select_i != 2'd3)
    else $error("invalid plane code");

  // request stall only after a held sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_i) |-> $past(out_valid_i && out_stall_i))
    else $error("request stall without downstream backpressure");

endmodule

bind yuv420_color_bar_pattern_generator yccb_checker u_yccb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_i     (in_stall_o),
  .out_valid_i    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .plane_select_i (plane_select_o),
  .column_i       (column_o),
  .sample_value_i (sample_value_o),
  .frame_end_i    (frame_end_o)
);

[verif/yccb_sample_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yccb_sample_checker: sample predictor and scoreboard for the bar generator
// Follows the register writes and every accepted request transaction, computes
// the planar sample each one must produce and compares the accepted results
// against the oldest pending sample, field by field.
// ----------------------------------------------------------------------------
module yccb_sample_checker
  import yccb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 restart_frame_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [PLANE_W-1:0]   plane_select_i,
  input  logic [COL_W-1:0]     column_i,
  input  logic [LINE_W-1:0]    line_number_i,
  input  logic [SAMPLE_W-1:0]  sample_value_i,
  input  logic                 frame_end_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          outstanding_o
);

  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int unsigned      col_cnt;
  int unsigned      line_cnt;
  int unsigned      ticker_col;
  plane_e           plane_now;
  result_t          sample_q [$];

  function automatic logic [SAMPLE_W-1:0] bar_level(logic [BAR_W-1:0] bar, plane_e plane);
    int red;
    int green;
    int blue;
    int acc;
    int offset;
    int level;
    red   = bar[1] ? 16 : 235;
    green = bar[2] ? 16 : 235;
    blue  = bar[0] ? 16 : 235;
    case (plane)
      PLANE_Y: begin
        acc    = 66 * red + 129 * green + 25 * blue;
        offset = 16;
      end
      PLANE_U: begin
        acc    = -38 * red - 74 * green + 112 * blue;
        offset = 128;
      end
      default: begin
        acc    = 112 * red - 94 * green - 18 * blue;
        offset = 128;
      end
    endcase
    level = ((acc + 128) >>> 8) + offset;
    if (level < 0) level = 0;
    if (level > 255) level = 255;
    return level[SAMPLE_W-1:0];
  endfunction

  task automatic next_bar_sample(input logic restart, output result_t sample);
    int unsigned w;
    int unsigned h;
    int unsigned bar_w;
    int unsigned plane_w;
    int unsigned plane_h;
    int unsigned scaled;
    int unsigned bar;
    logic [SAMPLE_W-1:0] level;
    w = width_reg;
    if (w < MIN_WIDTH) w = MIN_WIDTH;
    if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
    h = height_reg;
    if (h < MIN_HEIGHT) h = MIN_HEIGHT;
    if (h > DEF_MAX_HEIGHT) h = DEF_MAX_HEIGHT;
    bar_w = w / NUM_BARS;

    if (restart) begin
      col_cnt    = 0;
      line_cnt   = 0;
      plane_now  = PLANE_Y;
      ticker_col = 0;
    end
    if (ticker_col >= w) ticker_col = 0;

    plane_w = (plane_now == PLANE_Y) ? w : w / 2;
    plane_h = (plane_now == PLANE_Y) ? h : h / 2;
    // position left outside the plane by a size change
    if (col_cnt >= plane_w || line_cnt >= plane_h) begin
      col_cnt   = 0;
      line_cnt  = 0;
      plane_now = PLANE_Y;
      plane_w   = w;
      plane_h   = h;
    end

    scaled = (plane_now == PLANE_Y) ? col_cnt : col_cnt * 2;
    bar    = scaled / bar_w;
    if (bar > NUM_BARS - 1) bar = NUM_BARS - 1;
    level = bar_level(BAR_W'(bar), plane_now);
    if (plane_now == PLANE_Y && col_cnt >= ticker_col && col_cnt < ticker_col + TICKER_COLS)
      level = TICKER_LUMA;

    sample.plane_select = plane_now;
    sample.column       = COL_W'(col_cnt);
    sample.line_number  = LINE_W'(line_cnt);
    sample.sample_value = level;
    sample.frame_end    = (plane_now == PLANE_V && col_cnt == plane_w - 1 &&
                           line_cnt == plane_h - 1);

    col_cnt++;
    if (col_cnt >= plane_w) begin
      col_cnt = 0;
      line_cnt++;
      if (line_cnt >= plane_h) begin
        line_cnt = 0;
        case (plane_now)
          PLANE_Y: plane_now = PLANE_U;
          PLANE_U: plane_now = PLANE_V;
          default: begin
            plane_now  = PLANE_Y;
            ticker_col = ticker_col + TICKER_COLS;
            if (ticker_col >= w) ticker_col = ticker_col - w;
          end
        endcase
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    logic    bad;
    if (!rst_ni) begin
      width_reg        = CFG_W'(RESET_FRAME_WIDTH);
      height_reg       = CFG_W'(RESET_FRAME_HEIGHT);
      col_cnt          = 0;
      line_cnt         = 0;
      ticker_col       = 0;
      plane_now        = PLANE_Y;
      mismatch_count_o = 0;
      outstanding_o    = 0;
      sample_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.plane_select = plane_select_i;
        got.column       = column_i;
        got.line_number  = line_number_i;
        got.sample_value = sample_value_i;
        got.frame_end    = frame_end_i;
        if (sample_q.size() == 0) begin
          $display("%0t: unexpected sample transaction, expected none actual %h", $time, got);
          mismatch_count_o++;
        end else begin
          want = sample_q.pop_front();
          bad  = 1'b0;
          if (got.plane_select !== want.plane_select) begin
            $display("%0t: plane_select expected %0d actual %0d",
                     $time, want.plane_select, got.plane_select);
            bad = 1'b1;
          end
          if (got.column !== want.column) begin
            $display("%0t: column expected %0d actual %0d", $time, want.column, got.column);
            bad = 1'b1;
          end
          if (got.line_number !== want.line_number) begin
            $display("%0t: line_number expected %0d actual %0d",
                     $time, want.line_number, got.line_number);
            bad = 1'b1;
          end
          if (got.sample_value !== want.sample_value) begin
            $display("%0t: sample_value expected %0d actual %0d",
                     $time, want.sample_value, got.sample_value);
            bad = 1'b1;
          end
          if (got.frame_end !== want.frame_end) begin
            $display("%0t: frame_end expected %0d actual %0d",
                     $time, want.frame_end, got.frame_end);
            bad = 1'b1;
          end
          if (bad) mismatch_count_o++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FRAME_WIDTH:  width_reg  = cfg_wdata_i;
          REG_FRAME_HEIGHT: height_reg = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        next_bar_sample(restart_frame_i, want);
        sample_q.push_back(want);
      end
      outstanding_o = sample_q.size();
    end
  end

endmodule

[verif/tb_yuv420_color_bar_pattern_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_yuv420_color_bar_pattern_generator: colour bar generator regression
// Drives request transactions through a set of frame sizes, including sizes
// clamped at both ends and odd sizes, with random idle and stall bursts on
// both channels; the sample checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_yuv420_color_bar_pattern_generator;
  import yccb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned PHASES       = 10;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  cfg_reg_e             cfg_index_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 restart_frame_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [PLANE_W-1:0]   plane_select_o;
  logic [COL_W-1:0]     column_o;
  logic [LINE_W-1:0]    line_number_o;
  logic [SAMPLE_W-1:0]  sample_value_o;
  logic                 frame_end_o;
  int unsigned          mismatch_count;
  int unsigned          outstanding;
  int unsigned          idle_rate;
  int unsigned          cycle_count;

  int unsigned phase_width  [PHASES] = '{8, 13, 7, 40, 16, 4096, 8191, 24, 8, 32};
  int unsigned phase_height [PHASES] = '{2, 5, 1, 3, 4, 8191, 7, 0, 2, 2};
  int unsigned phase_items  [PHASES] = '{150, 160, 120, 200, 150, 80, 100, 180, 150, 260};
  int unsigned phase_idle   [PHASES] = '{20, 20, 30, 0, 25, 20, 15, 20, 30, 0};

  yuv420_color_bar_pattern_generator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .restart_frame_i (restart_frame_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .plane_select_o  (plane_select_o),
    .column_o        (column_o),
    .line_number_o   (line_number_o),
    .sample_value_o  (sample_value_o),
    .frame_end_o     (frame_end_o)
  );

  yccb_sample_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .restart_frame_i  (restart_frame_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .plane_select_i   (plane_select_o),
    .column_i         (column_o),
    .line_number_i    (line_number_o),
    .sample_value_i   (sample_value_o),
    .frame_end_i      (frame_end_o),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // receiver stall bursts
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_rate != 0 && $urandom_range(0, 199) < idle_rate) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
    end
  end

  task automatic send_request(input logic restart);
    @(negedge clk_i);
    in_valid_i      = 1'b1;
    restart_frame_i = restart;
    do @(posedge clk_i); while (in_stall_o);
    if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate) begin
      @(negedge clk_i);
      in_valid_i      = 1'b0;
      restart_frame_i = 1'($urandom_range(0, 1));
      repeat ($urandom_range(0, 15)) @(negedge clk_i);
    end
  endtask

  task automatic drain_samples();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_frame_size(input int unsigned width, input int unsigned height);
    drain_samples();
    cfg_we_i    = 1'b1;
    cfg_index_i = REG_FRAME_WIDTH;
    cfg_wdata_i = CFG_W'(width);
    @(negedge clk_i);
    cfg_index_i = REG_FRAME_HEIGHT;
    cfg_wdata_i = CFG_W'(height);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = REG_FRAME_WIDTH;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    restart_frame_i = 1'b0;
    idle_rate       = 15;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // ticker columns at reset size, then a shrink that leaves the position outside
    send_request(1'b0);
    send_request(1'b1);
    repeat (7) send_request(1'b0);
    set_frame_size(8, 2);
    repeat (24) send_request(1'b0);

    for (int p = 0; p < PHASES; p++) begin
      idle_rate = phase_idle[p];
      set_frame_size(phase_width[p], phase_height[p]);
      repeat (phase_items[p]) send_request($urandom_range(0, 39) == 0);
    end

    drain_samples();
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
